/* hdl/kab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_pkg: shared types and constants for the angle/bias Kalman filter
// Fixed-point formats, saturation helpers, sequencer and divider state codes,
// and the structs passed between the filter's modules.
// ----------------------------------------------------------------------------
package kab_pkg;

    // Field width and fixed-point formats.
    localparam int DATA_WIDTH  = 32;
    localparam int DT_FRAC     = 28;   // time step is Q4.28
    localparam int GAIN_FRAC   = 24;   // gains and covariance are Q8.24
    localparam int QBDT_SHIFT  = 34;   // Q2.30 noise times Q4.28 step down to Q8.24
    localparam int NOISE_SHIFT = 6;    // Q2.30 noise down to Q8.24

    // Datapath widths.
    localparam int ALU_W     = DATA_WIDTH + 8;
    localparam int MUL_W     = DATA_WIDTH + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DEN_W     = DATA_WIDTH + 1;
    localparam int NOISE_W   = DATA_WIDTH - NOISE_SHIFT + 1;
    localparam int DIV_STEPS = DATA_WIDTH;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [ALU_W-1:0]      alu_t;
    typedef logic signed [MUL_W-1:0]      mul_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DEN_W-1:0]      den_t;
    typedef logic [NOISE_W-1:0]           noise_t;
    typedef logic [DIV_CNT_W-1:0]         div_cnt_t;

    localparam div_cnt_t DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam alu_t  SAT_HI   = {{(ALU_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam alu_t  SAT_LO   = {{(ALU_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    // Raw reset values of the noise registers, unsigned Q2.30.
    localparam logic [DATA_WIDTH-1:0] ANGLE_NOISE_RESET = 32'd1073742;
    localparam logic [DATA_WIDTH-1:0] BIAS_NOISE_RESET  = 32'd3221225;
    localparam logic [DATA_WIDTH-1:0] MEAS_NOISE_RESET  = 32'd32212255;

    // Noise terms as the datapath uses them.
    typedef struct packed {
        noise_t                qa;   // angle process noise, Q8.24, rounded
        logic [DATA_WIDTH-1:0] qb;   // bias process noise, raw Q2.30
        noise_t                r;    // measurement noise, Q8.24, rounded
    } cfg_t;

    typedef struct packed {
        logic  start;
        data_t num;
        den_t  den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        data_t quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_T,
        ST_ANG,
        ST_P11,
        ST_INNER1,
        ST_INNER2,
        ST_INNER3,
        ST_P01,
        ST_P00,
        ST_P10,
        ST_S,
        ST_D0_GO,
        ST_D0_WAIT,
        ST_D1_GO,
        ST_D1_WAIT,
        ST_Y,
        ST_KY0,
        ST_ANGC,
        ST_BIAS,
        ST_C10,
        ST_C00,
        ST_C11,
        ST_C01,
        ST_OUT
    } state_t;

    // Which register takes the result of a step.
    typedef enum logic [3:0] {
        DST_NONE,
        DST_RATE,
        DST_T,
        DST_ANG,
        DST_W,
        DST_Y,
        DST_BIAS,
        DST_AA,
        DST_AB,
        DST_BA,
        DST_BB,
        DST_K0,
        DST_K1
    } dst_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_PREP,
        DV_CHECK,
        DV_ITER,
        DV_FIN,
        DV_DONE
    } div_state_t;

    // Round a Q2.30 noise value to Q8.24, half toward plus infinity.
    function automatic noise_t noise_round(input logic [DATA_WIDTH-1:0] v);
        noise_round = noise_t'(v >> NOISE_SHIFT) + noise_t'(v[NOISE_SHIFT-1]);
    endfunction

    function automatic alu_t ext_data(input data_t x);
        ext_data = alu_t'(x);
    endfunction

    function automatic data_t sat_data(input alu_t x);
        if (x > SAT_HI) begin
            sat_data = DATA_MAX;
        end else if (x < SAT_LO) begin
            sat_data = DATA_MIN;
        end else begin
            sat_data = x[DATA_WIDTH-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/kab_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_cfg: noise configuration registers
// Decodes register writes and keeps the noise terms in the form the datapath
// uses: angle and measurement noise are rounded to Q8.24 when written.
// ----------------------------------------------------------------------------
module kab_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kab_pkg::DATA_WIDTH-1:0]     cfg_wdata,
    output kab_pkg::cfg_t                           cfg
);

    kab_pkg::noise_t                qa_reg, qa_next;
    logic [kab_pkg::DATA_WIDTH-1:0] qb_reg, qb_next;
    kab_pkg::noise_t                r_reg,  r_next;

    always_comb begin
        qa_next = qa_reg;
        qb_next = qb_reg;
        r_next  = r_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                kab_pkg::CFG_ANGLE_NOISE: qa_next = kab_pkg::noise_round(cfg_wdata);
                kab_pkg::CFG_BIAS_NOISE:  qb_next = cfg_wdata;
                kab_pkg::CFG_MEAS_NOISE:  r_next  = kab_pkg::noise_round(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= kab_pkg::noise_round(kab_pkg::ANGLE_NOISE_RESET);
            qb_reg <= kab_pkg::BIAS_NOISE_RESET;
            r_reg  <= kab_pkg::noise_round(kab_pkg::MEAS_NOISE_RESET);
        end else begin
            qa_reg <= qa_next;
            qb_reg <= qb_next;
            r_reg  <= r_next;
        end
    end

    assign cfg.qa = qa_reg;
    assign cfg.qb = qb_reg;
    assign cfg.r  = r_reg;

endmodule
`default_nettype wire

/* hdl/kab_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_mul: shared signed multiplier
// One 33 x 33 signed multiply per cycle with a registered product. Unsigned
// operands are zero-extended by the caller.
// ----------------------------------------------------------------------------
module kab_mul (
    input  wire logic          aclk,
    input  kab_pkg::mul_t      op_a,
    input  kab_pkg::mul_t      op_b,
    output kab_pkg::prod_t     prod_reg
);

    kab_pkg::prod_t prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

/* hdl/kab_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_div: serial gain divider
// Computes sat((num << 24) / den), truncated toward zero, one quotient bit
// per cycle. A zero divisor gives zero; a quotient of 2^32 or more in
// magnitude saturates before the bit loop starts.
// ----------------------------------------------------------------------------
module kab_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  kab_pkg::div_req_t req,
    output kab_pkg::div_rsp_t rsp
);

    kab_pkg::div_state_t              state_reg, state_next;
    kab_pkg::data_t                   num_reg, num_next;
    kab_pkg::den_t                    den_reg, den_next;
    logic                             neg_reg, neg_next;
    logic                             zero_reg, zero_next;
    logic                             ovf_reg, ovf_next;
    logic [kab_pkg::DATA_WIDTH-1:0]   nmag_reg, nmag_next;
    logic [kab_pkg::DEN_W-1:0]        dmag_reg, dmag_next;
    logic [kab_pkg::DEN_W-1:0]        rem_reg, rem_next;
    logic [kab_pkg::DATA_WIDTH-1:0]   quo_reg, quo_next;
    kab_pkg::div_cnt_t                cnt_reg, cnt_next;
    kab_pkg::data_t                   q_reg, q_next;

    logic [kab_pkg::DEN_W-1:0]        rem_top;
    logic                             chk_zero;
    logic                             chk_ovf;
    logic [kab_pkg::DEN_W:0]          rem_shift;
    logic [kab_pkg::DEN_W+1:0]        rem_diff;
    logic                             rem_ge;
    logic                             quo_over_neg;

    // The upper bits of the shifted dividend form the first partial remainder.
    assign rem_top  = {{(kab_pkg::DEN_W-kab_pkg::GAIN_FRAC){1'b0}},
                       nmag_reg[kab_pkg::DATA_WIDTH-1 -: kab_pkg::GAIN_FRAC]};
    assign chk_zero = (dmag_reg == '0);
    assign chk_ovf  = (rem_top >= dmag_reg);

    assign rem_shift = {rem_reg, quo_reg[kab_pkg::DATA_WIDTH-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, dmag_reg};
    assign rem_ge    = !rem_diff[kab_pkg::DEN_W+1];

    assign quo_over_neg = quo_reg[kab_pkg::DATA_WIDTH-1]
                          && (|quo_reg[kab_pkg::DATA_WIDTH-2:0]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kab_pkg::DV_IDLE: begin
                if (req.start) begin
                    state_next = kab_pkg::DV_PREP;
                end
            end
            kab_pkg::DV_PREP:  state_next = kab_pkg::DV_CHECK;
            kab_pkg::DV_CHECK: begin
                if (chk_zero || chk_ovf) begin
                    state_next = kab_pkg::DV_FIN;
                end else begin
                    state_next = kab_pkg::DV_ITER;
                end
            end
            kab_pkg::DV_ITER: begin
                if (cnt_reg == kab_pkg::DIV_LAST) begin
                    state_next = kab_pkg::DV_FIN;
                end
            end
            kab_pkg::DV_FIN:  state_next = kab_pkg::DV_DONE;
            kab_pkg::DV_DONE: state_next = kab_pkg::DV_IDLE;
            default:          state_next = kab_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        ovf_next  = ovf_reg;
        nmag_next = nmag_reg;
        dmag_next = dmag_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        unique case (state_reg)
            kab_pkg::DV_IDLE: begin
                if (req.start) begin
                    num_next = req.num;
                    den_next = req.den;
                end
            end
            kab_pkg::DV_PREP: begin
                neg_next  = num_reg[kab_pkg::DATA_WIDTH-1] ^ den_reg[kab_pkg::DEN_W-1];
                nmag_next = num_reg[kab_pkg::DATA_WIDTH-1] ? (~num_reg + 1'b1) : num_reg;
                dmag_next = den_reg[kab_pkg::DEN_W-1] ? (~den_reg + 1'b1) : den_reg;
            end
            kab_pkg::DV_CHECK: begin
                zero_next = chk_zero;
                ovf_next  = chk_ovf;
                rem_next  = rem_top;
                quo_next  = {nmag_reg[kab_pkg::DATA_WIDTH-kab_pkg::GAIN_FRAC-1:0],
                             {kab_pkg::GAIN_FRAC{1'b0}}};
                cnt_next  = '0;
            end
            kab_pkg::DV_ITER: begin
                // The dividend bits leave the top of quo_reg as quotient bits enter below.
                rem_next = rem_ge ? rem_diff[kab_pkg::DEN_W-1:0]
                                  : rem_shift[kab_pkg::DEN_W-1:0];
                quo_next = {quo_reg[kab_pkg::DATA_WIDTH-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            kab_pkg::DV_FIN: begin
                if (zero_reg) begin
                    q_next = '0;
                end else if (neg_reg) begin
                    q_next = (ovf_reg || quo_over_neg) ? kab_pkg::DATA_MIN
                                                       : $signed(~quo_reg + 1'b1);
                end else begin
                    q_next = (ovf_reg || quo_reg[kab_pkg::DATA_WIDTH-1]) ? kab_pkg::DATA_MAX
                                                                         : $signed(quo_reg);
                end
            end
            kab_pkg::DV_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kab_pkg::DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
    end

    assign rsp.done = (state_reg == kab_pkg::DV_DONE);
    assign rsp.quot = q_reg;

endmodule
`default_nettype wire

/* hdl/kalman_angle_bias_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state Kalman filter for angle and gyro bias
// Fuses a gyro rate with an accelerometer angle. A small sequencer steps one
// shared add/saturate unit and one shared multiplier through the predict and
// correct equations; the two gains come from a serial divider.
//
//   Channel  | Ports                                   | Dir | Transfer
//   ---------+-----------------------------------------+-----+------------------
//   input    | s_valid s_ready s_prior_angle           | in  | valid and ready
//            | s_gyro_rate s_accel_angle s_time_step   |     |
//   result   | m_valid m_ready m_filtered_angle        | out | valid and ready
//            | m_bias_estimate                         |     |
//   config   | cfg_wr_en cfg_index cfg_wdata           | in  | write, no wait
//
// The block accepts a new item only after the last one has reached its result
// register, and the two gain divisions take up most of that time. A division
// skips its bit loop when the divisor is zero or the quotient is 2^32 or more
// in magnitude, so a zero divisor shortens the item. The result register frees
// the block for the next item while a result waits; a stall on m_ready holds
// the block only in its last step. Reset is synchronous: the bias and
// covariance clear and the noise registers return to their defaults.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  kab_pkg::data_t                          s_prior_angle,
    input  kab_pkg::data_t                          s_gyro_rate,
    input  kab_pkg::data_t                          s_accel_angle,
    input  wire logic [kab_pkg::DATA_WIDTH-1:0]     s_time_step,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output kab_pkg::data_t                          m_filtered_angle,
    output kab_pkg::data_t                          m_bias_estimate,

    input  wire logic                               cfg_wr_en,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kab_pkg::DATA_WIDTH-1:0]     cfg_wdata
);

    kab_pkg::state_t                state_reg, state_next;

    kab_pkg::data_t                 prior_reg, gyro_reg, accel_reg;
    logic [kab_pkg::DATA_WIDTH-1:0] dt_reg;
    kab_pkg::data_t                 rate_reg, ang_reg, y_reg, k0_reg, k1_reg;
    kab_pkg::alu_t                  t_reg, w_reg;
    kab_pkg::data_t                 bias_reg, cov_aa_reg, cov_ab_reg, cov_ba_reg, cov_bb_reg;
    logic                           m_valid_reg;
    kab_pkg::data_t                 m_angle_reg, m_bias_reg;

    kab_pkg::cfg_t                  cfg;
    kab_pkg::mul_t                  mul_a, mul_b;
    kab_pkg::prod_t                 prod_reg;
    kab_pkg::div_req_t              div_req;
    kab_pkg::div_rsp_t              div_rsp;

    kab_pkg::alu_t                  alu_a, alu_b, alu_sum, alu_res;
    logic                           alu_cin, alu_sat;
    kab_pkg::data_t                 alu_data;
    kab_pkg::dst_t                  dst;
    logic                           out_load;

    kab_pkg::alu_t                  prod_r28, prod_r24, prod_r34;
    logic                           rnd28, rnd24, rnd34;
    kab_pkg::mul_t                  dt_op;

    kab_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kab_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    kab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Rounding shifts: floor(p / 2^s) plus the bit just below the cut.
    assign prod_r28 = kab_pkg::alu_t'(prod_reg >>> kab_pkg::DT_FRAC);
    assign rnd28    = prod_reg[kab_pkg::DT_FRAC-1];
    assign prod_r24 = kab_pkg::alu_t'(prod_reg >>> kab_pkg::GAIN_FRAC);
    assign rnd24    = prod_reg[kab_pkg::GAIN_FRAC-1];
    assign prod_r34 = kab_pkg::alu_t'(prod_reg >>> kab_pkg::QBDT_SHIFT);
    assign rnd34    = prod_reg[kab_pkg::QBDT_SHIFT-1];

    assign dt_op = $signed({1'b0, dt_reg});

    assign alu_sum  = alu_a + alu_b + {{(kab_pkg::ALU_W-1){1'b0}}, alu_cin};
    assign alu_res  = alu_sat ? kab_pkg::ext_data(kab_pkg::sat_data(alu_sum)) : alu_sum;
    assign alu_data = alu_res[kab_pkg::DATA_WIDTH-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kab_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = kab_pkg::ST_RATE;
                end
            end
            kab_pkg::ST_RATE:    state_next = kab_pkg::ST_T;
            kab_pkg::ST_T:       state_next = kab_pkg::ST_ANG;
            kab_pkg::ST_ANG:     state_next = kab_pkg::ST_P11;
            kab_pkg::ST_P11:     state_next = kab_pkg::ST_INNER1;
            kab_pkg::ST_INNER1:  state_next = kab_pkg::ST_INNER2;
            kab_pkg::ST_INNER2:  state_next = kab_pkg::ST_INNER3;
            kab_pkg::ST_INNER3:  state_next = kab_pkg::ST_P01;
            kab_pkg::ST_P01:     state_next = kab_pkg::ST_P00;
            kab_pkg::ST_P00:     state_next = kab_pkg::ST_P10;
            kab_pkg::ST_P10:     state_next = kab_pkg::ST_S;
            kab_pkg::ST_S:       state_next = kab_pkg::ST_D0_GO;
            kab_pkg::ST_D0_GO:   state_next = kab_pkg::ST_D0_WAIT;
            kab_pkg::ST_D0_WAIT: begin
                if (div_rsp.done) begin
                    state_next = kab_pkg::ST_D1_GO;
                end
            end
            kab_pkg::ST_D1_GO:   state_next = kab_pkg::ST_D1_WAIT;
            kab_pkg::ST_D1_WAIT: begin
                if (div_rsp.done) begin
                    state_next = kab_pkg::ST_Y;
                end
            end
            kab_pkg::ST_Y:       state_next = kab_pkg::ST_KY0;
            kab_pkg::ST_KY0:     state_next = kab_pkg::ST_ANGC;
            kab_pkg::ST_ANGC:    state_next = kab_pkg::ST_BIAS;
            kab_pkg::ST_BIAS:    state_next = kab_pkg::ST_C10;
            kab_pkg::ST_C10:     state_next = kab_pkg::ST_C00;
            kab_pkg::ST_C00:     state_next = kab_pkg::ST_C11;
            kab_pkg::ST_C11:     state_next = kab_pkg::ST_C01;
            kab_pkg::ST_C01:     state_next = kab_pkg::ST_OUT;
            kab_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = kab_pkg::ST_IDLE;
                end
            end
            default:             state_next = kab_pkg::ST_IDLE;
        endcase
    end

    // Some steps drive the multiplier for a later step, and steps that add a
    // product take the one issued one step earlier. Subtracting a rounded
    // product uses the inverted shift and the inverted rounding bit as carry.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        alu_a    = '0;
        alu_b    = '0;
        alu_cin  = 1'b0;
        alu_sat  = 1'b1;
        dst      = kab_pkg::DST_NONE;
        div_req  = '0;
        out_load = 1'b0;
        unique case (state_reg)
            kab_pkg::ST_IDLE: ;
            kab_pkg::ST_RATE: begin
                mul_a   = dt_op;
                mul_b   = kab_pkg::mul_t'(cov_bb_reg);
                alu_a   = kab_pkg::ext_data(gyro_reg);
                alu_b   = ~kab_pkg::ext_data(bias_reg);
                alu_cin = 1'b1;
                dst     = kab_pkg::DST_RATE;
            end
            kab_pkg::ST_T: begin
                mul_a   = dt_op;
                mul_b   = kab_pkg::mul_t'(rate_reg);
                alu_a   = prod_r28;
                alu_cin = rnd28;
                alu_sat = 1'b0;
                dst     = kab_pkg::DST_T;
            end
            kab_pkg::ST_ANG: begin
                mul_a   = $signed({1'b0, cfg.qb});
                mul_b   = dt_op;
                alu_a   = kab_pkg::ext_data(prior_reg);
                alu_b   = prod_r28;
                alu_cin = rnd28;
                dst     = kab_pkg::DST_ANG;
            end
            kab_pkg::ST_P11: begin
                alu_a   = kab_pkg::ext_data(cov_bb_reg);
                alu_b   = prod_r34;
                alu_cin = rnd34;
                dst     = kab_pkg::DST_BB;
            end
            kab_pkg::ST_INNER1: begin
                alu_a   = t_reg;
                alu_b   = ~kab_pkg::ext_data(cov_ab_reg);
                alu_cin = 1'b1;
                alu_sat = 1'b0;
                dst     = kab_pkg::DST_W;
            end
            kab_pkg::ST_INNER2: begin
                alu_a   = w_reg;
                alu_b   = ~kab_pkg::ext_data(cov_ba_reg);
                alu_cin = 1'b1;
                alu_sat = 1'b0;
                dst     = kab_pkg::DST_W;
            end
            kab_pkg::ST_INNER3: begin
                alu_a = w_reg;
                alu_b = kab_pkg::alu_t'({1'b0, cfg.qa});
                dst   = kab_pkg::DST_W;
            end
            kab_pkg::ST_P01: begin
                mul_a   = dt_op;
                mul_b   = kab_pkg::mul_t'($signed(w_reg[kab_pkg::DATA_WIDTH-1:0]));
                alu_a   = kab_pkg::ext_data(cov_ab_reg);
                alu_b   = ~t_reg;
                alu_cin = 1'b1;
                dst     = kab_pkg::DST_AB;
            end
            kab_pkg::ST_P00: begin
                alu_a   = kab_pkg::ext_data(cov_aa_reg);
                alu_b   = prod_r28;
                alu_cin = rnd28;
                dst     = kab_pkg::DST_AA;
            end
            kab_pkg::ST_P10: begin
                alu_a   = kab_pkg::ext_data(cov_ba_reg);
                alu_b   = ~t_reg;
                alu_cin = 1'b1;
                dst     = kab_pkg::DST_BA;
            end
            kab_pkg::ST_S: begin
                alu_a   = kab_pkg::ext_data(cov_aa_reg);
                alu_b   = kab_pkg::alu_t'({1'b0, cfg.r});
                alu_sat = 1'b0;
                dst     = kab_pkg::DST_W;
            end
            kab_pkg::ST_D0_GO: begin
                div_req.start = 1'b1;
                div_req.num   = cov_aa_reg;
                div_req.den   = $signed(w_reg[kab_pkg::DEN_W-1:0]);
            end
            kab_pkg::ST_D0_WAIT: begin
                if (div_rsp.done) begin
                    dst = kab_pkg::DST_K0;
                end
            end
            kab_pkg::ST_D1_GO: begin
                div_req.start = 1'b1;
                div_req.num   = cov_ba_reg;
                div_req.den   = $signed(w_reg[kab_pkg::DEN_W-1:0]);
            end
            kab_pkg::ST_D1_WAIT: begin
                if (div_rsp.done) begin
                    dst = kab_pkg::DST_K1;
                end
            end
            kab_pkg::ST_Y: begin
                alu_a   = kab_pkg::ext_data(accel_reg);
                alu_b   = ~kab_pkg::ext_data(ang_reg);
                alu_cin = 1'b1;
                dst     = kab_pkg::DST_Y;
            end
            kab_pkg::ST_KY0: begin
                mul_a = kab_pkg::mul_t'(k0_reg);
                mul_b = kab_pkg::mul_t'(y_reg);
            end
            kab_pkg::ST_ANGC: begin
                mul_a   = kab_pkg::mul_t'(k1_reg);
                mul_b   = kab_pkg::mul_t'(y_reg);
                alu_a   = kab_pkg::ext_data(ang_reg);
                alu_b   = prod_r24;
                alu_cin = rnd24;
                dst     = kab_pkg::DST_ANG;
            end
            kab_pkg::ST_BIAS: begin
                mul_a   = kab_pkg::mul_t'(k1_reg);
                mul_b   = kab_pkg::mul_t'(cov_aa_reg);
                alu_a   = kab_pkg::ext_data(bias_reg);
                alu_b   = prod_r24;
                alu_cin = rnd24;
                dst     = kab_pkg::DST_BIAS;
            end
            kab_pkg::ST_C10: begin
                mul_a   = kab_pkg::mul_t'(k0_reg);
                mul_b   = kab_pkg::mul_t'(cov_aa_reg);
                alu_a   = kab_pkg::ext_data(cov_ba_reg);
                alu_b   = ~prod_r24;
                alu_cin = ~rnd24;
                dst     = kab_pkg::DST_BA;
            end
            kab_pkg::ST_C00: begin
                mul_a   = kab_pkg::mul_t'(k1_reg);
                mul_b   = kab_pkg::mul_t'(cov_ab_reg);
                alu_a   = kab_pkg::ext_data(cov_aa_reg);
                alu_b   = ~prod_r24;
                alu_cin = ~rnd24;
                dst     = kab_pkg::DST_AA;
            end
            kab_pkg::ST_C11: begin
                mul_a   = kab_pkg::mul_t'(k0_reg);
                mul_b   = kab_pkg::mul_t'(cov_ab_reg);
                alu_a   = kab_pkg::ext_data(cov_bb_reg);
                alu_b   = ~prod_r24;
                alu_cin = ~rnd24;
                dst     = kab_pkg::DST_BB;
            end
            kab_pkg::ST_C01: begin
                alu_a   = kab_pkg::ext_data(cov_ab_reg);
                alu_b   = ~prod_r24;
                alu_cin = ~rnd24;
                dst     = kab_pkg::DST_AB;
            end
            kab_pkg::ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kab_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Filter state: cleared by reset. The covariance registers also hold the
    // predicted values between the predict and correct steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg   <= '0;
            cov_aa_reg <= '0;
            cov_ab_reg <= '0;
            cov_ba_reg <= '0;
            cov_bb_reg <= '0;
        end else begin
            unique case (dst)
                kab_pkg::DST_BIAS: bias_reg   <= alu_data;
                kab_pkg::DST_AA:   cov_aa_reg <= alu_data;
                kab_pkg::DST_AB:   cov_ab_reg <= alu_data;
                kab_pkg::DST_BA:   cov_ba_reg <= alu_data;
                kab_pkg::DST_BB:   cov_bb_reg <= alu_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            prior_reg <= s_prior_angle;
            gyro_reg  <= s_gyro_rate;
            accel_reg <= s_accel_angle;
            dt_reg    <= s_time_step;
        end
        unique case (dst)
            kab_pkg::DST_RATE: rate_reg <= alu_data;
            kab_pkg::DST_T:    t_reg    <= alu_res;
            kab_pkg::DST_ANG:  ang_reg  <= alu_data;
            kab_pkg::DST_W:    w_reg    <= alu_res;
            kab_pkg::DST_Y:    y_reg    <= alu_data;
            kab_pkg::DST_K0:   k0_reg   <= div_rsp.quot;
            kab_pkg::DST_K1:   k1_reg   <= div_rsp.quot;
            default: ;
        endcase
        if (out_load) begin
            m_angle_reg <= ang_reg;
            m_bias_reg  <= bias_reg;
        end
    end

    assign s_ready          = (state_reg == kab_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_filtered_angle = m_angle_reg;
    assign m_bias_estimate  = m_bias_reg;

endmodule
`default_nettype wire

/* test/kalman_angle_bias_checker.sv */
// ----------------------------------------------------------------------------
// kalman_angle_bias_checker: result checker for the angle/bias Kalman filter
// Watches the input, result and configuration ports, runs its own fixed-point
// copy of the filter on every accepted item and compares each result, field by
// field, with the oldest outstanding estimate.
// ----------------------------------------------------------------------------
module kalman_angle_bias_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  kab_pkg::data_t                          s_prior_angle,
    input  kab_pkg::data_t                          s_gyro_rate,
    input  kab_pkg::data_t                          s_accel_angle,
    input  wire logic [kab_pkg::DATA_WIDTH-1:0]     s_time_step,

    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  kab_pkg::data_t                          m_filtered_angle,
    input  kab_pkg::data_t                          m_bias_estimate,

    input  wire logic                               cfg_wr_en,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kab_pkg::DATA_WIDTH-1:0]     cfg_wdata,

    output int                                      fail_count,
    output int                                      pending,
    output int                                      results_seen,
    output int                                      zero_gain_hits
);
    import kab_pkg::*;

    typedef struct packed {
        data_t angle;
        data_t bias;
    } estimate_t;

    // Noise registers, raw unsigned Q2.30.
    logic [DATA_WIDTH-1:0] noise_angle;
    logic [DATA_WIDTH-1:0] noise_bias;
    logic [DATA_WIDTH-1:0] noise_meas;

    // Filter state: bias in Q16.16, covariance in Q8.24.
    data_t est_bias;
    data_t cov_aa;
    data_t cov_ab;
    data_t cov_ba;
    data_t cov_bb;

    estimate_t expected_estimates[$];

    // Right shift that rounds half toward plus infinity.
    function automatic longint shr_round(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_q(input longint x);
        if (x > longint'(DATA_MAX)) begin
            return longint'(DATA_MAX);
        end else if (x < longint'(DATA_MIN)) begin
            return longint'(DATA_MIN);
        end
        return x;
    endfunction

    // One predict/correct pass; updates the state and returns the new estimate.
    function automatic estimate_t filter_step(input data_t prior, input data_t gyro,
                                              input data_t accel,
                                              input logic [DATA_WIDTH-1:0] step_raw);
        longint dt, qa, r, rate, ang, t, inner, p00, p01, p10, p11, s, k0, k1, y;
        longint unsigned qbdt;
        estimate_t est;

        dt = longint'(step_raw);
        qa = shr_round(longint'(noise_angle), NOISE_SHIFT);
        r  = shr_round(longint'(noise_meas), NOISE_SHIFT);

        rate = sat_q(longint'(gyro) - longint'(est_bias));
        ang  = sat_q(longint'(prior) + shr_round(dt * rate, DT_FRAC));

        p11   = longint'(cov_bb);
        t     = shr_round(dt * p11, DT_FRAC);
        inner = sat_q(t - longint'(cov_ab) - longint'(cov_ba) + qa);
        p00   = sat_q(longint'(cov_aa) + shr_round(dt * inner, DT_FRAC));
        p01   = sat_q(longint'(cov_ab) - t);
        p10   = sat_q(longint'(cov_ba) - t);
        qbdt  = longint'(noise_bias) * longint'(step_raw);
        qbdt  = (qbdt >> QBDT_SHIFT) + ((qbdt >> (QBDT_SHIFT - 1)) & 64'd1);
        p11   = sat_q(p11 + longint'(qbdt));

        s = p00 + r;
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
            zero_gain_hits++;
        end else begin
            k0 = sat_q((p00 <<< GAIN_FRAC) / s);
            k1 = sat_q((p10 <<< GAIN_FRAC) / s);
        end

        y   = sat_q(longint'(accel) - ang);
        ang = sat_q(ang + shr_round(k0 * y, GAIN_FRAC));
        est_bias = data_t'(sat_q(longint'(est_bias) + shr_round(k1 * y, GAIN_FRAC)));

        // The correction uses the predicted P00 and P01, not the updated ones.
        cov_aa = data_t'(sat_q(p00 - shr_round(k0 * p00, GAIN_FRAC)));
        cov_ab = data_t'(sat_q(p01 - shr_round(k0 * p01, GAIN_FRAC)));
        cov_ba = data_t'(sat_q(p10 - shr_round(k1 * p00, GAIN_FRAC)));
        cov_bb = data_t'(sat_q(p11 - shr_round(k1 * p01, GAIN_FRAC)));

        est.angle = data_t'(ang);
        est.bias  = est_bias;
        return est;
    endfunction

    always @(posedge aclk) begin
        estimate_t want;
        if (!aresetn) begin
            noise_angle    = ANGLE_NOISE_RESET;
            noise_bias     = BIAS_NOISE_RESET;
            noise_meas     = MEAS_NOISE_RESET;
            est_bias       = '0;
            cov_aa         = '0;
            cov_ab         = '0;
            cov_ba         = '0;
            cov_bb         = '0;
            fail_count     = 0;
            results_seen   = 0;
            zero_gain_hits = 0;
            expected_estimates.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ANGLE_NOISE: noise_angle = cfg_wdata;
                    CFG_BIAS_NOISE:  noise_bias  = cfg_wdata;
                    CFG_MEAS_NOISE:  noise_meas  = cfg_wdata;
                    default: ;
                endcase
            end
            // Results leave before new items enter, so a result is never matched
            // against the item accepted on the same edge.
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_estimates.size() == 0) begin
                    $error("result with no item outstanding: filtered_angle %0d, bias_estimate %0d",
                           m_filtered_angle, m_bias_estimate);
                    fail_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_filtered_angle !== want.angle) begin
                        $error("filtered_angle mismatch: expected %0d, actual %0d",
                               want.angle, m_filtered_angle);
                        fail_count++;
                    end
                    if (m_bias_estimate !== want.bias) begin
                        $error("bias_estimate mismatch: expected %0d, actual %0d",
                               want.bias, m_bias_estimate);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_estimates.push_back(filter_step(s_prior_angle, s_gyro_rate,
                                                         s_accel_angle, s_time_step));
            end
        end
        pending = expected_estimates.size();
    end

endmodule

/* test/tb_kalman_angle_bias_filter.sv */
// ----------------------------------------------------------------------------
// tb_kalman_angle_bias_filter: testbench for the angle/bias Kalman filter
// Drives directed corner items and then random IMU-like and full-range items
// under several noise settings, with random gaps on both channels and one long
// result stall; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_kalman_angle_bias_filter;
    import kab_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int LONG_HOLD     = 800;
    localparam int SETTLE_CYCLES = 100;
    localparam int ANGLE_SPAN    = 180 << 16;   // +/-180 degrees in Q16.16
    localparam int RATE_SPAN     = 500 << 16;   // +/-500 degrees per second
    localparam int ACCEL_SPAN    = 20 << 16;    // accel angle scatter around the prior
    localparam int STEP_MAX      = 1 << 24;     // about 62 ms in Q4.28

    // Index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    data_t                 s_prior_angle;
    data_t                 s_gyro_rate;
    data_t                 s_accel_angle;
    logic [DATA_WIDTH-1:0] s_time_step;
    logic                  m_valid;
    logic                  m_ready;
    data_t                 m_filtered_angle;
    data_t                 m_bias_estimate;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_WIDTH-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int results_seen;
    int zero_gain_hits;
    int items_sent     = 0;
    int settings_used  = 0;
    bit tx_idle_on     = 1'b0;
    bit rx_idle_on     = 1'b0;
    bit hold_req       = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    kalman_angle_bias_filter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_prior_angle    (s_prior_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_accel_angle    (s_accel_angle),
        .s_time_step      (s_time_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_angle (m_filtered_angle),
        .m_bias_estimate  (m_bias_estimate),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    kalman_angle_bias_checker estimate_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_prior_angle    (s_prior_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_accel_angle    (s_accel_angle),
        .s_time_step      (s_time_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_angle (m_filtered_angle),
        .m_bias_estimate  (m_bias_estimate),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_seen     (results_seen),
        .zero_gain_hits   (zero_gain_hits)
    );

    function automatic data_t span_rand(input int span);
        return data_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Full-range word, biased toward the extremes of a 32-bit field.
    function automatic logic [DATA_WIDTH-1:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_item(input data_t prior, input data_t gyro, input data_t accel,
                             input logic [DATA_WIDTH-1:0] dt);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_prior_angle <= prior;
        s_gyro_rate   <= gyro;
        s_accel_angle <= accel;
        s_time_step   <= dt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_noise(input logic [DATA_WIDTH-1:0] qa,
                                 input logic [DATA_WIDTH-1:0] qb,
                                 input logic [DATA_WIDTH-1:0] r);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ANGLE_NOISE;
        cfg_wdata <= qa;
        @(negedge aclk);
        cfg_index <= CFG_BIAS_NOISE;
        cfg_wdata <= qb;
        @(negedge aclk);
        cfg_index <= CFG_MEAS_NOISE;
        cfg_wdata <= r;
        @(negedge aclk);
        // A write to the unused index must leave every register as it is.
        cfg_index <= CFG_SPARE;
        cfg_wdata <= $urandom;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    task automatic run_phase(input logic [DATA_WIDTH-1:0] qa,
                             input logic [DATA_WIDTH-1:0] qb,
                             input logic [DATA_WIDTH-1:0] r,
                             input int count, input bit idle, input bit long_hold);
        data_t prior;
        program_noise(qa, qb, r);
        tx_idle_on = idle;
        rx_idle_on = idle;
        for (int i = 0; i < count; i++) begin
            if (long_hold && i == count / 3) begin
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_item(corner_word(), corner_word(), corner_word(), corner_word());
            end else begin
                // Plausible IMU sample; a zero step now and then.
                prior = span_rand(ANGLE_SPAN);
                send_item(prior, span_rand(RATE_SPAN), prior + span_rand(ACCEL_SPAN),
                          ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(0, STEP_MAX));
            end
        end
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, rx_idle_on ? 20 : 1)) @(negedge aclk);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results outstanding.", pending);
        $display("FAILURE");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_prior_angle = '0;
        s_gyro_rate   = '0;
        s_accel_angle = '0;
        s_time_step   = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_ANGLE_NOISE;
        cfg_wdata     = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Field extremes under the reset noise values.
        send_item('0, '0, '0, '0);
        send_item(DATA_MAX, DATA_MAX, DATA_MAX, '1);
        send_item(DATA_MIN, DATA_MIN, DATA_MIN, '1);
        send_item(DATA_MAX, DATA_MIN, DATA_MIN, 32'h1000_0000);
        send_item(DATA_MIN, DATA_MAX, DATA_MAX, 32'h8000_0000);
        send_item('0, 32'sd1, -32'sd1, 32'd1);
        s_valid <= 1'b0;
        @(negedge aclk);

        // With no angle or measurement noise, P00 collapses to zero after one
        // item, so a zero time step then leaves a zero divisor.
        program_noise('0, '1, '0);
        repeat (3) send_item(32'sd65536, '0, -32'sd65536, '0);
        // A full-scale step grows P11 and drives the cross terms negative.
        send_item('0, DATA_MAX, DATA_MIN, '1);
        send_item(DATA_MIN, '0, DATA_MAX, 32'h0100_0000);
        send_item('0, '0, '0, '0);
        s_valid <= 1'b0;
        @(negedge aclk);

        run_phase(ANGLE_NOISE_RESET, BIAS_NOISE_RESET, MEAS_NOISE_RESET, 150, 1'b1, 1'b1);
        run_phase('1, '1, '1, 110, 1'b1, 1'b0);
        run_phase('0, '0, '0, 110, 1'b1, 1'b0);
        run_phase($urandom, $urandom, $urandom, 110, 1'b1, 1'b0);
        run_phase(32'd1, 32'd1, 32'd32, 110, 1'b1, 1'b0);
        run_phase($urandom_range(0, 1 << 28), $urandom_range(0, 1 << 28),
                  $urandom_range(0, 1 << 28), 150, 1'b0, 1'b0);

        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES * 2) @(negedge aclk);

        $display("Sent %0d items under %0d noise settings; %0d results checked.",
                 items_sent, settings_used + 1, results_seen);
        $display("%0d items hit a zero gain divisor; one result stall of %0d cycles.",
                 zero_gain_hits, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/kab_pkg.sv
hdl/kab_cfg.sv
hdl/kab_mul.sv
hdl/kab_div.sv
hdl/kalman_angle_bias_filter.sv
test/kalman_angle_bias_checker.sv
test/tb_kalman_angle_bias_filter.sv
